// ===== rtl/core/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the script token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] number_bits;
      logic [11:0] pool_offset;
      logic [63:0] name_low;
      logic [63:0] name_high;
      logic [3:0]  name_length;
      logic [3:0]  error_code;
      logic [23:0] line_number;
      logic        last_of_run;
   } rsp_type;

   localparam logic [4:0] K_EOF     = 5'd0;
   localparam logic [4:0] K_NEWLINE = 5'd1;
   localparam logic [4:0] K_STRING  = 5'd2;
   localparam logic [4:0] K_NUMBER  = 5'd3;
   localparam logic [4:0] K_IDENT   = 5'd4;
   localparam logic [4:0] K_COMMA   = 5'd5;
   localparam logic [4:0] K_LPAREN  = 5'd6;
   localparam logic [4:0] K_RPAREN  = 5'd7;
   localparam logic [4:0] K_LBRACK  = 5'd8;
   localparam logic [4:0] K_RBRACK  = 5'd9;
   localparam logic [4:0] K_PLUS    = 5'd10;
   localparam logic [4:0] K_STAR    = 5'd11;
   localparam logic [4:0] K_SLASH   = 5'd12;
   localparam logic [4:0] K_PCT     = 5'd13;
   localparam logic [4:0] K_AMP     = 5'd14;
   localparam logic [4:0] K_BAR     = 5'd15;
   localparam logic [4:0] K_CARET   = 5'd16;
   localparam logic [4:0] K_TILDE   = 5'd17;
   localparam logic [4:0] K_MINUS   = 5'd18;
   localparam logic [4:0] K_ARROW   = 5'd19;
   localparam logic [4:0] K_SHR     = 5'd20;
   localparam logic [4:0] K_GE      = 5'd21;
   localparam logic [4:0] K_GT      = 5'd22;
   localparam logic [4:0] K_SHL     = 5'd23;
   localparam logic [4:0] K_LE      = 5'd24;
   localparam logic [4:0] K_LT      = 5'd25;
   localparam logic [4:0] K_EQEQ    = 5'd26;
   localparam logic [4:0] K_NE      = 5'd27;
   localparam logic [4:0] K_ERROR   = 5'd28;

   localparam logic [3:0] E_NONE   = 4'd0;
   localparam logic [3:0] E_UNTERM = 4'd1;
   localparam logic [3:0] E_ESC    = 4'd2;
   localparam logic [3:0] E_POOL   = 4'd3;
   localparam logic [3:0] E_RANGE  = 4'd4;
   localparam logic [3:0] E_HEX    = 4'd5;
   localparam logic [3:0] E_BIN    = 4'd6;
   localparam logic [3:0] E_EQ     = 4'd7;
   localparam logic [3:0] E_BANG   = 4'd8;
   localparam logic [3:0] E_CHAR   = 4'd9;

   localparam logic       CSR_STRICT = 1'b0;
   localparam logic       CSR_DELIM  = 1'b1;

   localparam logic [23:0] LINE_TOP = 24'hFFFFFF;

endpackage

// ===== rtl/core/script_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// script_token_lexer_unit
// Byte-stream tokenizer with a string pool memory and one byte of lookahead.
//
//   channel | ports  | direction | content
//   req     | req_*  | in        | one source byte or end mark
//   rsp     | rsp_*  | out       | one token, up to two per request
//   csr     | csr_*  | in        | strict_delimiter, line_delimiter
//
// One request per cycle while req_ready is high; the lexer state updates at the
// accept edge, where its tokens enter the response queue, and the string pool
// takes at most one write per request.
// Tokens pass through a four-entry queue; a request is taken only while two
// entries are free, so a stalled consumer stops requests once three tokens wait.
// Synchronous reset clears control state; the pool is not cleared.
// ----------------------------------------------------------------------------
module script_token_lexer_unit #(
   parameter int POOL_DEPTH = 4096,
   parameter int NAME_MAX   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stl_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);
   localparam int PW = $clog2(POOL_DEPTH);
   localparam int FW = PW + 1;
   localparam int KEEP = (NAME_MAX - 1 < 15) ? NAME_MAX - 1 : 15;

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_ZERO, M_DEC, M_HEX, M_BIN,
      M_STR, M_ESC, M_MINUS, M_GT, M_LT, M_EQ, M_BANG, M_DEAD
   } mode_type;

   typedef enum logic [1:0] {F_NONE, F_CR, F_LF} fold_type;

   logic [7:0] pool_mem [POOL_DEPTH];

   logic        strict_ff;
   logic [7:0]  delim_ff;
   mode_type    mode_ff, mode_in;
   logic [31:0] acc_ff, acc_in;
   logic        seen_ff, seen_in;
   logic [7:0]  name_ff [15];
   logic [7:0]  name_in [15];
   logic [3:0]  ncnt_ff, ncnt_in;
   logic [23:0] line_ff, line_in;
   fold_type    fold_ff, fold_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [PW-1:0] start_ff, start_in;

   logic        pw_en;
   logic [7:0]  pw_data;
   logic        room, take;
   logic        push_a, push_b;
   stl_pkg::rsp_type tok_a, tok_b;

   logic [7:0] c;
   logic       have;

   assign req_ready = room;
   assign take = req_valid && room;
   assign c = req_data.ch;
   assign have = !req_data.end_mark;

   function automatic logic is_head(input logic [7:0] x);
      return (x >= 8'h41 && x <= 8'h5A) || (x >= 8'h61 && x <= 8'h7A) || x == 8'h5F;
   endfunction

   function automatic logic is_num_char(input logic [7:0] x);
      return x >= 8'h30 && x <= 8'h39;
   endfunction

   // token builders write into tok_a or tok_b in order
   always_comb begin
      stl_pkg::rsp_type t;
      logic [2:0] n;
      logic used, done, crlf;
      logic [35:0] prod;
      logic [4:0] base_sh;
      logic [7:0] d;
      logic [7:0] e;
      logic ends_l, soft_brk;
      logic [63:0] lo, hi;

      mode_in = mode_ff; acc_in = acc_ff; seen_in = seen_ff; name_in = name_ff;
      ncnt_in = ncnt_ff; line_in = line_ff; fold_in = fold_ff; fill_in = fill_ff;
      start_in = start_ff; pw_en = 1'b0; pw_data = '0;
      tok_a = '0; tok_b = '0; push_a = 1'b0; push_b = 1'b0;
      n = '0; used = 1'b0; done = 1'b0; prod = '0; base_sh = '0; d = '0;
      e = '0; lo = '0; hi = '0; ends_l = 1'b0; soft_brk = 1'b0;
      t = '0;
      crlf = 1'b0;

      if (take && mode_ff != M_DEAD) begin
         if (have) begin
            fold_in = F_NONE;
            crlf = mode_ff == M_IDLE &&
               ((fold_ff == F_CR && c == 8'h0A) || (fold_ff == F_LF && c == 8'h0D));
         end else begin
            fold_in = F_NONE;
         end
         if (!crlf) begin
            // resolve held token
            if (mode_in == M_ZERO) begin
               if (have && (c == 8'h78 || c == 8'h58)) begin
                  mode_in = M_HEX; acc_in = '0; seen_in = 1'b0; used = 1'b1; done = 1'b1;
               end else if (have && (c == 8'h62 || c == 8'h42)) begin
                  mode_in = M_BIN; acc_in = '0; seen_in = 1'b0; used = 1'b1; done = 1'b1;
               end else begin
                  mode_in = M_DEC;
               end
            end
            if (!done) begin
               t = '0;
               t.line_number = line_in;
               case (mode_in)
                  M_SLASH: begin
                     if (have && c == 8'h2F) begin
                        mode_in = M_COMMENT; used = 1'b1;
                     end else begin
                        mode_in = M_IDLE;
                        if (strict_ff && delim_ff == 8'h2F) begin
                           t.kind = stl_pkg::K_NEWLINE; n = n + 3'd1;
                           if (line_in < stl_pkg::LINE_TOP) line_in = line_in + 24'd1;
                        end else begin
                           t.kind = stl_pkg::K_SLASH; n = n + 3'd1;
                        end
                     end
                  end
                  M_COMMENT: begin
                     if (have && c != 8'h0D && c != 8'h0A) used = 1'b1;
                     else mode_in = M_IDLE;
                  end
                  M_IDENT: begin
                     if (have && (is_head(c) || is_num_char(c))) begin
                        if (32'(ncnt_in) < 32'(KEEP)) begin
                           name_in[ncnt_in] = c;
                           ncnt_in = ncnt_in + 4'd1;
                        end
                        used = 1'b1;
                     end else begin
                        for (int i = 0; i < 8; i++) begin
                           if (4'(i) < ncnt_in) lo[i*8 +: 8] = name_in[i];
                        end
                        for (int i = 8; i < 15; i++) begin
                           if (4'(i) < ncnt_in) hi[(i-8)*8 +: 8] = name_in[i];
                        end
                        t.kind = stl_pkg::K_IDENT; t.name_low = lo; t.name_high = hi;
                        t.name_length = ncnt_in; n = n + 3'd1; mode_in = M_IDLE;
                     end
                  end
                  M_DEC, M_HEX, M_BIN: begin
                     if (mode_in == M_DEC) begin
                        base_sh = 5'd10;
                     end else if (mode_in == M_HEX) begin
                        base_sh = 5'd16;
                     end else begin
                        base_sh = 5'd2;
                     end
                     d = 8'hFF;
                     if (have) begin
                        if (is_num_char(c)) d = c - 8'h30;
                        else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
                        else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
                     end
                     if (have && c == 8'h5F) begin
                        used = 1'b1;
                     end else if (have && d != 8'hFF && d < {3'd0, base_sh}) begin
                        prod = 36'(acc_in) * 36'(base_sh) + 36'(d);
                        seen_in = 1'b1; used = 1'b1;
                        if (prod > 36'hFFFFFFFF) begin
                           t.kind = stl_pkg::K_ERROR; t.error_code = stl_pkg::E_RANGE;
                           n = n + 3'd1; mode_in = M_DEAD;
                        end else begin
                           acc_in = prod[31:0];
                        end
                     end else if (mode_in != M_DEC && !seen_in) begin
                        t.kind = stl_pkg::K_ERROR;
                        t.error_code = (mode_in == M_HEX) ? stl_pkg::E_HEX : stl_pkg::E_BIN;
                        n = n + 3'd1; mode_in = M_DEAD; used = 1'b1;
                     end else begin
                        t.kind = stl_pkg::K_NUMBER; t.number_bits = acc_in;
                        n = n + 3'd1; mode_in = M_IDLE;
                     end
                  end
                  M_STR, M_ESC: begin
                     used = 1'b1;
                     e = c;
                     if (mode_in == M_STR) begin
                        if (!have || c == 8'h0D || c == 8'h0A) begin
                           t.kind = stl_pkg::K_ERROR; t.error_code = stl_pkg::E_UNTERM;
                           n = n + 3'd1; mode_in = M_DEAD;
                        end else if (c == 8'h5C) begin
                           mode_in = M_ESC;
                        end else begin
                           pw_en = 1'b1;
                           pw_data = (c == 8'h22) ? 8'h00 : c;
                        end
                     end else begin
                        case (c)
                           8'h72: e = 8'h0D;
                           8'h6E: e = 8'h0A;
                           8'h74: e = 8'h09;
                           8'h5C: e = 8'h5C;
                           8'h22: e = 8'h22;
                           default: e = 8'h00;
                        endcase
                        if (!have || e == 8'h00) begin
                           t.kind = stl_pkg::K_ERROR; t.error_code = stl_pkg::E_ESC;
                           n = n + 3'd1; mode_in = M_DEAD;
                        end else begin
                           mode_in = M_STR; pw_en = 1'b1; pw_data = e;
                        end
                     end
                     if (pw_en) begin
                        if (32'(fill_in) + 32'd1 >= 32'(POOL_DEPTH)) begin
                           pw_en = 1'b0;
                           t.kind = stl_pkg::K_ERROR; t.error_code = stl_pkg::E_POOL;
                           n = n + 3'd1; mode_in = M_DEAD;
                        end else begin
                           fill_in = fill_in + FW'(1);
                           if (mode_in == M_STR && c == 8'h22 && mode_ff == M_STR) begin
                              t.kind = stl_pkg::K_STRING;
                              t.pool_offset = 12'(start_in);
                              n = n + 3'd1; mode_in = M_IDLE;
                           end
                        end
                     end
                  end
                  M_MINUS: begin
                     mode_in = M_IDLE; n = n + 3'd1;
                     if (have && c == 8'h3E) begin
                        t.kind = stl_pkg::K_ARROW; used = 1'b1;
                     end else begin
                        t.kind = stl_pkg::K_MINUS;
                     end
                  end
                  M_GT: begin
                     mode_in = M_IDLE; n = n + 3'd1;
                     if (have && c == 8'h3E) begin
                        t.kind = stl_pkg::K_SHR; used = 1'b1;
                     end else if (have && c == 8'h3D) begin
                        t.kind = stl_pkg::K_GE; used = 1'b1;
                     end else begin
                        t.kind = stl_pkg::K_GT;
                     end
                  end
                  M_LT: begin
                     mode_in = M_IDLE; n = n + 3'd1;
                     if (have && c == 8'h3C) begin
                        t.kind = stl_pkg::K_SHL; used = 1'b1;
                     end else if (have && c == 8'h3D) begin
                        t.kind = stl_pkg::K_LE; used = 1'b1;
                     end else begin
                        t.kind = stl_pkg::K_LT;
                     end
                  end
                  M_EQ, M_BANG: begin
                     used = 1'b1; n = n + 3'd1;
                     if (have && c == 8'h3D) begin
                        t.kind = (mode_in == M_EQ) ? stl_pkg::K_EQEQ : stl_pkg::K_NE;
                        mode_in = M_IDLE;
                     end else begin
                        t.kind = stl_pkg::K_ERROR;
                        t.error_code = (mode_in == M_EQ) ? stl_pkg::E_EQ : stl_pkg::E_BANG;
                        mode_in = M_DEAD;
                     end
                  end
                  default: begin
                  end
               endcase
               if (n != 3'd0) tok_a = t;
            end
            // begin a fresh token with this byte
            if (have && !used && mode_in == M_IDLE) begin
               t = '0;
               t.line_number = line_in;
               ends_l = strict_ff ? (c == delim_ff) : (c == 8'h0D || c == 8'h0A);
               soft_brk = strict_ff && (c == 8'h0D || c == 8'h0A) && c != delim_ff;
               if (c == 8'h20 || c == 8'h09 || soft_brk) begin
               end else if (c == 8'h2F) begin
                  mode_in = M_SLASH;
               end else if (ends_l) begin
                  t.kind = stl_pkg::K_NEWLINE;
                  fold_in = (c == 8'h0D) ? F_CR : ((c == 8'h0A) ? F_LF : F_NONE);
                  if (line_in < stl_pkg::LINE_TOP) line_in = line_in + 24'd1;
                  if (n == 3'd0) tok_a = t; else tok_b = t;
                  n = n + 3'd1;
               end else if (c == 8'h22) begin
                  start_in = PW'(fill_in); mode_in = M_STR;
               end else if (is_num_char(c)) begin
                  acc_in = {24'd0, c - 8'h30}; seen_in = 1'b1;
                  mode_in = (c == 8'h30) ? M_ZERO : M_DEC;
               end else if (is_head(c)) begin
                  name_in[0] = c; ncnt_in = 4'd1; mode_in = M_IDENT;
               end else begin
                  case (c)
                     8'h2C: t.kind = stl_pkg::K_COMMA;
                     8'h28: t.kind = stl_pkg::K_LPAREN;
                     8'h29: t.kind = stl_pkg::K_RPAREN;
                     8'h5B: t.kind = stl_pkg::K_LBRACK;
                     8'h5D: t.kind = stl_pkg::K_RBRACK;
                     8'h2B: t.kind = stl_pkg::K_PLUS;
                     8'h2A: t.kind = stl_pkg::K_STAR;
                     8'h25: t.kind = stl_pkg::K_PCT;
                     8'h26: t.kind = stl_pkg::K_AMP;
                     8'h7C: t.kind = stl_pkg::K_BAR;
                     8'h5E: t.kind = stl_pkg::K_CARET;
                     8'h7E: t.kind = stl_pkg::K_TILDE;
                     8'h2D: mode_in = M_MINUS;
                     8'h3E: mode_in = M_GT;
                     8'h3C: mode_in = M_LT;
                     8'h3D: mode_in = M_EQ;
                     8'h21: mode_in = M_BANG;
                     default: begin
                        t.kind = stl_pkg::K_ERROR; t.error_code = stl_pkg::E_CHAR;
                        mode_in = M_DEAD;
                     end
                  endcase
                  if (t.kind != stl_pkg::K_EOF) begin
                     if (n == 3'd0) tok_a = t; else tok_b = t;
                     n = n + 3'd1;
                  end
               end
            end
            // end of source
            if (!have && mode_in != M_DEAD) begin
               t = '0;
               t.kind = stl_pkg::K_EOF;
               t.line_number = line_in;
               if (n == 3'd0) tok_a = t; else tok_b = t;
               n = n + 3'd1;
               line_in = 24'd1; mode_in = M_IDLE; acc_in = '0; seen_in = 1'b0;
               ncnt_in = '0;
            end
         end
         push_a = n != 3'd0;
         push_b = n == 3'd2;
         if (n == 3'd1) tok_a.last_of_run = 1'b1;
         if (n == 3'd2) tok_b.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
         delim_ff <= 8'd10;
         mode_ff <= M_IDLE;
         acc_ff <= '0;
         seen_ff <= 1'b0;
         ncnt_ff <= '0;
         line_ff <= 24'd1;
         fold_ff <= F_NONE;
         fill_ff <= '0;
         start_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == stl_pkg::CSR_STRICT) strict_ff <= csr_wdata[0];
            else delim_ff <= csr_wdata;
         end
         mode_ff <= mode_in;
         acc_ff <= acc_in;
         seen_ff <= seen_in;
         ncnt_ff <= ncnt_in;
         line_ff <= line_in;
         fold_ff <= fold_in;
         fill_ff <= fill_in;
         start_ff <= start_in;
      end
      name_ff <= name_in;
   end

   // string pool write port
   always_ff @(posedge clock) begin
      if (pw_en) pool_mem[fill_ff[PW-1:0]] <= pw_data;
   end

   stl_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .data_a    (tok_a),
      .push_b    (push_b),
      .data_b    (tok_b),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== rtl/core/stl_out_queue.sv =====
// ----------------------------------------------------------------------------
// stl_out_queue
// Four-entry response queue that decouples the lexer from the consumer.
// ----------------------------------------------------------------------------
module stl_out_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_a,
   input  stl_pkg::rsp_type data_a,
   input  logic            push_b,
   input  stl_pkg::rsp_type data_b,
   output logic            room,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output stl_pkg::rsp_type rsp_data
);
   stl_pkg::rsp_type slot_ff [4];
   logic [1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic pop;

   assign pop = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data = slot_ff[rd_ff];
   assign room = cnt_ff <= 3'd2;

   always_comb begin
      rd_in = rd_ff + 2'(pop);
      wr_in = wr_ff + 2'(push_a) + 2'(push_b);
      cnt_in = cnt_ff + 3'(push_a) + 3'(push_b) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push_a) slot_ff[wr_ff] <= data_a;
      if (push_b) slot_ff[wr_ff + 2'(push_a)] <= data_b;
   end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for script_token_lexer_unit. Source text is built from
// directed cases and random well-formed token streams under several line
// delimiter settings; a behavioral tokenizer in the bench predicts every token
// and each response is compared with the oldest prediction. The run closes
// with one fatal lexing error, after which the lexer must stay silent.
// ----------------------------------------------------------------------------
module testbench;

   localparam int POOL_DEPTH = 4096;
   localparam int NAME_KEEP  = 15;
   localparam int STALL_LIMIT = 20000;

   typedef enum int {
      S_IDLE, S_SLASH, S_COMMENT, S_IDENT, S_ZERO, S_DEC, S_HEX, S_BIN,
      S_STR, S_ESC, S_MINUS, S_GT, S_LT, S_EQ, S_BANG, S_DEAD
   } scan_type;
   typedef enum int { FOLD_NONE, FOLD_CR, FOLD_LF } fold_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   stl_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   stl_pkg::rsp_type rsp_data;
   logic    csr_write = 0;
   logic    csr_index = stl_pkg::CSR_STRICT;
   logic [7:0] csr_wdata = '0;

   script_token_lexer_unit uut (.*);

   always #1 clock = ~clock;

   // tokenizer state mirrored in the bench
   logic        strict_mode;
   logic [7:0]  delim;
   scan_type    scan;
   logic [31:0] acc;
   logic        got_digit;
   logic [7:0]  name_buf [NAME_KEEP];
   int          name_len;
   logic [23:0] cur_line;
   fold_type    fold;
   int          pool_fill;
   int          str_start;

   stl_pkg::rsp_type token_q [$];
   int          step_tokens;
   int          mismatches = 0;
   int          sent = 0;
   bit          idling = 1;
   byte unsigned txt [$];

   // ---------------- token predictor ----------------
   function automatic void push_token(logic [4:0] k);
      stl_pkg::rsp_type t;
      t = '0;
      t.kind = k;
      t.line_number = cur_line;
      token_q.push_back(t);
      step_tokens++;
   endfunction

   function automatic void lex_fail(logic [3:0] code);
      push_token(stl_pkg::K_ERROR);
      token_q[token_q.size()-1].error_code = code;
      scan = S_DEAD;
   endfunction

   function automatic bit is_line_end(int c);
      return strict_mode ? (c == delim) : (c == 13 || c == 10);
   endfunction

   function automatic bit is_soft_break(int c);
      return strict_mode && (c == 13 || c == 10) && c != delim;
   endfunction

   function automatic bit is_name_head(int c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic bit is_name_char(int c);
      return is_name_head(c) || (c >= "0" && c <= "9");
   endfunction

   function automatic void count_line(int c);
      push_token(stl_pkg::K_NEWLINE);
      fold = (c == 13) ? FOLD_CR : ((c == 10) ? FOLD_LF : FOLD_NONE);
      if (cur_line != stl_pkg::LINE_TOP) cur_line++;
   endfunction

   function automatic void finish_op(logic [4:0] k);
      push_token(k);
      scan = S_IDLE;
   endfunction

   function automatic void finish_number();
      push_token(stl_pkg::K_NUMBER);
      token_q[token_q.size()-1].number_bits = acc;
      scan = S_IDLE;
   endfunction

   function automatic void finish_name();
      stl_pkg::rsp_type t;
      push_token(stl_pkg::K_IDENT);
      t = token_q[token_q.size()-1];
      for (int i = 0; i < name_len; i++) begin
         if (i < 8) t.name_low[8*i +: 8] = name_buf[i];
         else t.name_high[8*(i-8) +: 8] = name_buf[i];
      end
      t.name_length = 4'(name_len);
      token_q[token_q.size()-1] = t;
      scan = S_IDLE;
   endfunction

   function automatic void pool_store();
      if (pool_fill + 1 >= POOL_DEPTH) lex_fail(stl_pkg::E_POOL);
      else pool_fill++;
   endfunction

   function automatic void add_digit(int base, int d);
      longint unsigned v;
      v = longint'(acc) * base + d;
      got_digit = 1;
      if (v > 64'hFFFF_FFFF) lex_fail(stl_pkg::E_RANGE);
      else acc = v[31:0];
   endfunction

   // returns 1 when the byte is consumed by the held token
   function automatic bit resolve_held(bit have, int c);
      if (scan == S_ZERO) begin
         if (have && (c == "x" || c == "X")) begin
            scan = S_HEX; acc = 0; got_digit = 0; return 1;
         end
         if (have && (c == "b" || c == "B")) begin
            scan = S_BIN; acc = 0; got_digit = 0; return 1;
         end
         scan = S_DEC;
      end
      case (scan)
         S_SLASH: begin
            if (have && c == "/") begin scan = S_COMMENT; return 1; end
            scan = S_IDLE;
            if (is_line_end("/")) count_line("/"); else finish_op(stl_pkg::K_SLASH);
            return 0;
         end
         S_COMMENT: begin
            if (have && c != 13 && c != 10) return 1;
            scan = S_IDLE;
            return 0;
         end
         S_IDENT: begin
            if (have && is_name_char(c)) begin
               if (name_len < NAME_KEEP) begin
                  name_buf[name_len] = 8'(c);
                  name_len++;
               end
               return 1;
            end
            finish_name();
            return 0;
         end
         S_DEC: begin
            if (have && c == "_") return 1;
            if (have && c >= "0" && c <= "9") begin add_digit(10, c - "0"); return 1; end
            finish_number();
            return 0;
         end
         S_HEX: begin
            if (have && c == "_") return 1;
            if (have && c >= "0" && c <= "9") begin add_digit(16, c - "0"); return 1; end
            if (have && c >= "a" && c <= "f") begin add_digit(16, c - "a" + 10); return 1; end
            if (have && c >= "A" && c <= "F") begin add_digit(16, c - "A" + 10); return 1; end
            if (!got_digit) begin lex_fail(stl_pkg::E_HEX); return 1; end
            finish_number();
            return 0;
         end
         S_BIN: begin
            if (have && c == "_") return 1;
            if (have && (c == "0" || c == "1")) begin add_digit(2, c - "0"); return 1; end
            if (!got_digit) begin lex_fail(stl_pkg::E_BIN); return 1; end
            finish_number();
            return 0;
         end
         S_STR: begin
            if (!have || c == 13 || c == 10) begin lex_fail(stl_pkg::E_UNTERM); return 1; end
            if (c == 34) begin
               pool_store();
               if (scan != S_DEAD) begin
                  push_token(stl_pkg::K_STRING);
                  token_q[token_q.size()-1].pool_offset = str_start[11:0];
                  scan = S_IDLE;
               end
            end else if (c == 92) scan = S_ESC;
            else pool_store();
            return 1;
         end
         S_ESC: begin
            if (!have || !(c inside {"r", "n", "t", 92, 34})) begin
               lex_fail(stl_pkg::E_ESC);
               return 1;
            end
            scan = S_STR;
            pool_store();
            return 1;
         end
         S_MINUS: begin
            if (have && c == ">") begin finish_op(stl_pkg::K_ARROW); return 1; end
            finish_op(stl_pkg::K_MINUS);
            return 0;
         end
         S_GT: begin
            if (have && c == ">") begin finish_op(stl_pkg::K_SHR); return 1; end
            if (have && c == "=") begin finish_op(stl_pkg::K_GE); return 1; end
            finish_op(stl_pkg::K_GT);
            return 0;
         end
         S_LT: begin
            if (have && c == "<") begin finish_op(stl_pkg::K_SHL); return 1; end
            if (have && c == "=") begin finish_op(stl_pkg::K_LE); return 1; end
            finish_op(stl_pkg::K_LT);
            return 0;
         end
         S_EQ: begin
            if (have && c == "=") begin finish_op(stl_pkg::K_EQEQ); return 1; end
            lex_fail(stl_pkg::E_EQ);
            return 1;
         end
         S_BANG: begin
            if (have && c == "=") begin finish_op(stl_pkg::K_NE); return 1; end
            lex_fail(stl_pkg::E_BANG);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic void start_token(int c);
      if (c == " " || c == 9 || is_soft_break(c)) return;
      if (c == "/") begin scan = S_SLASH; return; end
      if (is_line_end(c)) begin count_line(c); return; end
      if (c == 34) begin str_start = pool_fill; scan = S_STR; return; end
      if (c >= "0" && c <= "9") begin
         acc = 32'(c - "0");
         got_digit = 1;
         scan = (c == "0") ? S_ZERO : S_DEC;
         return;
      end
      if (is_name_head(c)) begin
         name_buf[0] = 8'(c); name_len = 1; scan = S_IDENT; return;
      end
      case (c)
         ",": finish_op(stl_pkg::K_COMMA);
         "(": finish_op(stl_pkg::K_LPAREN);
         ")": finish_op(stl_pkg::K_RPAREN);
         "[": finish_op(stl_pkg::K_LBRACK);
         "]": finish_op(stl_pkg::K_RBRACK);
         "+": finish_op(stl_pkg::K_PLUS);
         "*": finish_op(stl_pkg::K_STAR);
         "%": finish_op(stl_pkg::K_PCT);
         "&": finish_op(stl_pkg::K_AMP);
         "|": finish_op(stl_pkg::K_BAR);
         "^": finish_op(stl_pkg::K_CARET);
         "~": finish_op(stl_pkg::K_TILDE);
         "-": scan = S_MINUS;
         ">": scan = S_GT;
         "<": scan = S_LT;
         "=": scan = S_EQ;
         "!": scan = S_BANG;
         default: lex_fail(stl_pkg::E_CHAR);
      endcase
   endfunction

   function automatic void predict_tokens(stl_pkg::req_type r);
      fold_type f;
      step_tokens = 0;
      if (scan == S_DEAD) return;
      if (!r.end_mark) begin
         f = fold;
         fold = FOLD_NONE;
         if (scan == S_IDLE && ((f == FOLD_CR && r.ch == 10) || (f == FOLD_LF && r.ch == 13)))
            return;
         if (!resolve_held(1, r.ch) && scan == S_IDLE) start_token(r.ch);
      end else begin
         fold = FOLD_NONE;
         void'(resolve_held(0, 0));
         if (scan != S_DEAD) begin
            push_token(stl_pkg::K_EOF);
            cur_line = 1;
            scan = S_IDLE;
            acc = 0;
            got_digit = 0;
            name_len = 0;
         end
      end
      if (step_tokens > 0) token_q[token_q.size()-1].last_of_run = 1'b1;
   endfunction

   // ---------------- response side ----------------
   int stall_left = 0;
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!idling) rsp_ready <= 1'b1;
      else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      stl_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token: kind %0d line %0d", rsp_data.kind,
                        rsp_data.line_number);
         end else begin
            want = token_q.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.number_bits !== want.number_bits ||
                rsp_data.pool_offset !== want.pool_offset ||
                rsp_data.name_low !== want.name_low || rsp_data.name_high !== want.name_high ||
                rsp_data.name_length !== want.name_length ||
                rsp_data.error_code !== want.error_code ||
                rsp_data.line_number !== want.line_number ||
                rsp_data.last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------- request side ----------------
   task automatic send_request(logic [7:0] c, logic endm);
      int gap;
      gap = (idling && $urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.ch <= c;
      req_data.end_mark <= endm;
      do @(posedge clock); while (!req_ready);
      predict_tokens('{ch: c, end_mark: endm});
      sent++;
   endtask

   task automatic send_text();
      while (txt.size() > 0) send_request(txt.pop_front(), 1'b0);
   endtask

   task automatic send_end();
      send_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic put_str(string s);
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (token_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic strict_val, logic [7:0] delim_val);
      drain();
      csr_write <= 1'b1;
      csr_index <= stl_pkg::CSR_STRICT;
      csr_wdata <= {7'd0, strict_val};
      @(posedge clock);
      csr_index <= stl_pkg::CSR_DELIM;
      csr_wdata <= delim_val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      strict_mode = strict_val;
      delim = delim_val;
   endtask

   // ---------------- random text ----------------
   task automatic put_digits(string d, bit lead_sep);
      for (int i = 0; i < d.len(); i++) begin
         if ((i > 0 || lead_sep) && $urandom_range(0, 5) == 0) txt.push_back("_");
         txt.push_back(d[i]);
      end
   endtask

   task automatic put_name();
      int n;
      string pick;
      pick = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 8);
      txt.push_back(pick[$urandom_range(0, 52)]);
      for (int i = 1; i < n; i++) txt.push_back(pick[$urandom_range(0, 62)]);
   endtask

   task automatic put_string_lit();
      int n, c;
      string esc;
      esc = "rnt\\\"";
      n = $urandom_range(0, 10);
      txt.push_back(34);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            txt.push_back(92);
            txt.push_back(esc[$urandom_range(0, 4)]);
         end else begin
            do c = $urandom_range(0, 255); while (c inside {10, 13, 34, 92});
            txt.push_back(8'(c));
         end
      end
      txt.push_back(34);
   endtask

   task automatic put_line_end();
      if (strict_mode) begin
         if ($urandom_range(0, 2) == 0) txt.push_back(8'($urandom_range(0, 1) ? 10 : 13));
         txt.push_back(delim);
      end else
         case ($urandom_range(0, 4))
            0: txt.push_back(10);
            1: txt.push_back(13);
            2: begin txt.push_back(13); txt.push_back(10); end
            3: begin txt.push_back(10); txt.push_back(13); end
            default: begin txt.push_back(10); txt.push_back(10); end
         endcase
   endtask

   task automatic put_token();
      string ops [23];
      logic [31:0] v;
      int c;
      ops = '{",", "(", ")", "[", "]", "+", "*", "/", "%", "&", "|", "^", "~", "-",
              "->", ">>", ">=", ">", "<<", "<=", "<", "==", "!="};
      v = $urandom;
      case ($urandom_range(0, 10))
         0, 1: put_name();
         2: put_digits($sformatf("%0d", v), 0);
         3: begin
            put_str($urandom_range(0, 1) ? "0x" : "0X");
            put_digits($urandom_range(0, 1) ? $sformatf("%0h", v) : $sformatf("%0H", v), 1);
         end
         4: begin
            put_str($urandom_range(0, 1) ? "0b" : "0B");
            put_digits($sformatf("%0b", v >> $urandom_range(0, 31)), 1);
         end
         5: if (pool_fill < 3500) put_string_lit(); else put_name();
         6, 7: put_str(ops[$urandom_range(0, 22)]);
         8: put_line_end();
         9: begin
            put_str("//");
            repeat ($urandom_range(0, 6)) begin
               do c = $urandom_range(0, 255); while (c inside {10, 13});
               txt.push_back(8'(c));
            end
            txt.push_back(8'($urandom_range(0, 1) ? 10 : 13));
         end
         default: put_digits($sformatf("%0d", v[7:0]), 0);
      endcase
      txt.push_back(8'($urandom_range(0, 3) == 0 ? 9 : 32));
   endtask

   task automatic random_text(int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         put_token();
         send_text();
         if ($urandom_range(0, 40) == 0) send_end();
      end
      send_end();
   endtask

   // ---------------- tests ----------------
   task automatic test_operators();
      put_str(", ( ) [ ] + * / % & | ^ ~ - -> >> >= > << <= < == != -");
      send_text();
      send_end();
   endtask

   task automatic test_literals();
      put_str("4294967295 0 0xFFFF_ffff 0b1_0 007 Abcdefghijklmnopqrs _x9 \"\" \"a\\n\\\"\" 1");
      send_text();
      send_end();
   endtask

   task automatic test_line_ends();
      put_str("a\r\nb\n\rc\n\n// note\rd >");
      send_text();
      send_end();
   endtask

   task automatic test_hold_for_drain();
      put_str("x1 y2 ");
      send_text();
      drain();
      put_str("z3");
      send_text();
      send_end();
   endtask

   task automatic test_delimiters();
      logic [7:0] delims [6];
      delims = '{8'd10, 8'd13, 8'd0, 8'd255, ";", 8'd10};
      foreach (delims[i]) begin
         write_csr(i != 5, delims[i]);
         random_text(250);
      end
   endtask

   task automatic test_no_idling();
      drain();
      idling = 0;
      random_text(200);
   endtask

   task automatic test_fatal_error();
      int code;
      write_csr(1'b0, 8'd10);
      code = $urandom_range(1, 8);
      if (code >= 3) code++;
      case (code)
         1: put_str("\"ab\n");
         2: put_str("\"a\\q");
         4: put_str("99999999999");
         5: put_str("0x ");
         6: put_str("0b+");
         7: put_str("= ");
         8: put_str("!a");
         default: put_str("@");
      endcase
      put_str(" ok 12 ");
      send_text();
      send_end();
   endtask

   initial begin
      strict_mode = 0; delim = 10; scan = S_IDLE; acc = 0; got_digit = 0;
      name_len = 0; cur_line = 1; fold = FOLD_NONE; pool_fill = 0; str_start = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operators();
      test_literals();
      test_line_ends();
      test_hold_for_drain();
      test_delimiters();
      test_no_idling();
      test_fatal_error();
      req_valid <= 1'b0;
      while (token_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/stl_pkg.sv
rtl/core/stl_out_queue.sv
rtl/core/script_token_lexer_unit.sv
tb/testbench.sv
